/* src/mbps_pkg.sv */
// Shared types and register indexes for the masked byte pattern scanner.
`timescale 1ns / 1ps
`default_nettype none

package mbps_pkg;

  localparam int unsigned CFG_ADDR_W  = 2;
  localparam int unsigned CFG_DATA_W  = 64;
  localparam int unsigned PAT_BYTES   = 16;
  localparam int unsigned LEN_W       = 5;
  localparam int unsigned OFFSET_W    = 32;

  localparam logic [CFG_ADDR_W-1:0] CFG_PAT_LO = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_PAT_HI = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_CARE   = 2'd2;
  localparam logic [CFG_ADDR_W-1:0] CFG_LEN    = 2'd3;

  localparam logic [PAT_BYTES-1:0] CARE_RESET = '1;
  localparam logic [LEN_W-1:0]     LEN_RESET  = 5'd1;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } mbps_in_t;

  typedef struct packed {
    logic                found;
    logic [OFFSET_W-1:0] match_offset;
  } mbps_out_t;

  typedef struct packed {
    logic [63:0]          pat_lo;
    logic [63:0]          pat_hi;
    logic [PAT_BYTES-1:0] care;
    logic [LEN_W-1:0]     len;
  } mbps_cfg_t;

  typedef struct packed {
    logic                hit;
    logic [OFFSET_W-1:0] offset;
  } mbps_match_t;

endpackage

`default_nettype wire

/* src/mbps_cfg_regs.sv */
// Configuration register file: pattern, care mask and pattern length.
`timescale 1ns / 1ps
`default_nettype none

module mbps_cfg_regs
  import mbps_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  wr_en_i,
  input  wire logic [CFG_ADDR_W-1:0] wr_addr_i,
  input  wire logic [CFG_DATA_W-1:0] wr_data_i,
  output mbps_cfg_t                  cfg_o
);

  mbps_cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en_i) begin
      unique case (wr_addr_i)
        CFG_PAT_LO: cfg_d.pat_lo = wr_data_i;
        CFG_PAT_HI: cfg_d.pat_hi = wr_data_i;
        CFG_CARE:   cfg_d.care   = wr_data_i[PAT_BYTES-1:0];
        CFG_LEN:    cfg_d.len    = wr_data_i[LEN_W-1:0];
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.pat_lo <= '0;
      cfg_q.pat_hi <= '0;
      cfg_q.care   <= CARE_RESET;
      cfg_q.len    <= LEN_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

/* src/mbps_match.sv */
// Parallel masked compare of the byte history against the pattern.
`timescale 1ns / 1ps
`default_nettype none

module mbps_match
  import mbps_pkg::*;
#(
  parameter int unsigned MAX_PATTERN = 16,
  parameter int unsigned OFFSET_BITS = 32,
  parameter int unsigned WIN_DEPTH   = 15
) (
  input  wire logic                      [7:0] cur_i,
  input  wire logic [WIN_DEPTH-1:0]      [7:0] win_i,
  input  wire logic [OFFSET_BITS-1:0]          pos_i,
  input  wire mbps_cfg_t                       cfg_i,
  output mbps_match_t                          match_o
);

  localparam int unsigned IDX_W   = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
  localparam int unsigned HIST_D  = 2 ** IDX_W;
  localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_PATTERN);

  logic [HIST_D-1:0][7:0]        hist;
  logic [2*CFG_DATA_W-1:0]       pat;
  logic [LEN_W-1:0]              len;
  logic [LEN_W-1:0]              len_m1;
  logic [LEN_W-1:0]              back;
  logic                          all_eq;
  logic                          long_enough;
  logic [OFFSET_BITS-1:0]        start;

  always_comb begin
    for (int j = 0; j < HIST_D; j++) begin
      if (j == 0) begin
        hist[j] = cur_i;
      end else if (j < MAX_PATTERN && j <= WIN_DEPTH) begin
        hist[j] = win_i[j-1];
      end else begin
        hist[j] = '0;
      end
    end
  end

  assign pat    = {cfg_i.pat_hi, cfg_i.pat_lo};
  assign len    = (cfg_i.len > MAX_LEN) ? MAX_LEN : cfg_i.len;
  assign len_m1 = len - LEN_W'(1);

  // Pattern byte i lines up with the byte seen len-1-i items ago.
  always_comb begin
    all_eq = 1'b1;
    back   = '0;
    for (int i = 0; i < MAX_PATTERN; i++) begin
      back = len_m1 - LEN_W'(i);
      if (LEN_W'(i) < len && cfg_i.care[i] &&
          hist[back[IDX_W-1:0]] != pat[8*i +: 8]) begin
        all_eq = 1'b0;
      end
    end
  end

  assign long_enough = (len == '0) ||
                       (pos_i >= OFFSET_BITS'(len_m1));
  assign start       = (len == '0) ? pos_i : (pos_i - OFFSET_BITS'(len_m1));

  assign match_o.hit    = long_enough && all_eq;
  assign match_o.offset = OFFSET_W'(start);

endmodule

`default_nettype wire

/* src/masked_byte_pattern_scan.sv */
// Top level: input stage, byte window, offset counter and result register.
//
//  channel | direction | handshake               | payload
//  --------+-----------+-------------------------+---------------------------
//  in      | in        | in_valid_i / in_ready_o | in_i   (data_byte, last_byte)
//  out     | out       | out_valid_o/out_ready_i | out_o  (found, match_offset)
//  cfg     | in        | cfg_valid_i/cfg_ready_o | cfg_addr_i, cfg_data_i
//
// One item per cycle when the result side does not stall; an item goes first into the input
// register, then through the compare into the result register.
// The window compare and counter update are done as each byte leaves the input register.
// Reset clears the window, the offset counter, the reported flag and both
// registers' valid bits; pattern resets to zero, care mask to all ones,
// length to one. A stalled result holds the input stage, which then lowers
// in_ready_o. cfg_ready_o is always high.
`timescale 1ns / 1ps
`default_nettype none

module masked_byte_pattern_scan
  import mbps_pkg::*;
#(
  parameter int unsigned MAX_PATTERN = 16,
  parameter int unsigned OFFSET_BITS = 32
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output      logic                  in_ready_o,
  input  wire mbps_in_t              in_i,
  output      logic                  out_valid_o,
  input  wire logic                  out_ready_i,
  output mbps_out_t                  out_o,
  input  wire logic                  cfg_valid_i,
  output      logic                  cfg_ready_o,
  input  wire logic [CFG_ADDR_W-1:0] cfg_addr_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam int unsigned WIN_DEPTH = (MAX_PATTERN > 1) ? MAX_PATTERN - 1 : 1;

  mbps_cfg_t   cfg;
  mbps_match_t mres;

  logic     s1_valid_q, s1_valid_d;
  mbps_in_t s1_q, s1_d;

  logic [WIN_DEPTH-1:0][7:0] win_q, win_d;
  logic [OFFSET_BITS-1:0]    cnt_q, cnt_d;
  logic                      rep_q, rep_d;

  logic      out_valid_q, out_valid_d;
  mbps_out_t out_q, out_d;

  logic advance;
  logic emit;

  assign cfg_ready_o = 1'b1;

  mbps_cfg_regs u_cfg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (cfg_valid_i),
    .wr_addr_i (cfg_addr_i),
    .wr_data_i (cfg_data_i),
    .cfg_o     (cfg)
  );

  mbps_match #(
    .MAX_PATTERN (MAX_PATTERN),
    .OFFSET_BITS (OFFSET_BITS),
    .WIN_DEPTH   (WIN_DEPTH)
  ) u_match (
    .cur_i   (s1_q.data_byte),
    .win_i   (win_q),
    .pos_i   (cnt_q),
    .cfg_i   (cfg),
    .match_o (mres)
  );

  assign advance    = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || advance;
  assign emit       = !rep_q && (mres.hit || s1_q.last_byte);

  // Input stage
  always_comb begin
    s1_valid_d = s1_valid_q;
    s1_d       = s1_q;
    if (advance) begin
      s1_valid_d = 1'b0;
    end
    if (in_valid_i && in_ready_o) begin
      s1_valid_d = 1'b1;
      s1_d       = in_i;
    end
  end

  // Scan state
  always_comb begin
    win_d = win_q;
    cnt_d = cnt_q;
    rep_d = rep_q;
    if (advance) begin
      if (s1_q.last_byte) begin
        win_d = '0;
        cnt_d = '0;
        rep_d = 1'b0;
      end else begin
        for (int k = WIN_DEPTH - 1; k > 0; k--) begin
          win_d[k] = win_q[k-1];
        end
        win_d[0] = s1_q.data_byte;
        if (!(&cnt_q)) begin
          cnt_d = cnt_q + OFFSET_BITS'(1);
        end
        rep_d = rep_q || mres.hit;
      end
    end
  end

  // Result register
  always_comb begin
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (advance && emit) begin
      out_valid_d        = 1'b1;
      out_d.found        = mres.hit;
      out_d.match_offset = mres.hit ? mres.offset : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      win_q       <= '0;
      cnt_q       <= '0;
      rep_q       <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
      win_q       <= win_d;
      cnt_q       <= cnt_d;
      rep_q       <= rep_d;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_q  <= s1_d;
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

`ifndef ASSERT_OFF
  a_rep_after_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && !rep_q && mres.hit && !s1_q.last_byte |=> rep_q)
    else $error("reported flag not set after a match");

  a_clear_on_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && s1_q.last_byte |=> cnt_q == '0 && !rep_q)
    else $error("scan state not cleared after last byte");

  a_notfound_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_q.found |-> out_q.match_offset == '0)
    else $error("not-found result with nonzero offset");

  a_stage_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && !advance |=> s1_valid_q && $stable(s1_q))
    else $error("input stage lost an item while stalled");
`endif

endmodule

`default_nettype wire

/* bench/testbench.sv */
// Self-checking bench for masked_byte_pattern_scan: scan predictor, scoreboard and stimulus.
`timescale 1ns / 1ps

class scan_scoreboard;
  logic [63:0] pat_lo;
  logic [63:0] pat_hi;
  logic [15:0] care;
  logic [4:0]  len_reg;
  logic [7:0]  window [15];
  logic [31:0] seen;
  bit          reported;
  mbps_pkg::mbps_out_t pending_results [$];
  int errors;
  int n_bytes;
  int n_found;
  int n_missed;

  function new();
    pat_lo   = '0;
    pat_hi   = '0;
    care     = mbps_pkg::CARE_RESET;
    len_reg  = mbps_pkg::LEN_RESET;
    errors   = 0;
    n_bytes  = 0;
    n_found  = 0;
    n_missed = 0;
    clear_scan();
  endfunction

  function void clear_scan();
    foreach (window[k]) window[k] = '0;
    seen     = '0;
    reported = 1'b0;
  endfunction

  function void write_reg(logic [1:0] idx, logic [63:0] val);
    case (idx)
      mbps_pkg::CFG_PAT_LO: pat_lo = val;
      mbps_pkg::CFG_PAT_HI: pat_hi = val;
      mbps_pkg::CFG_CARE:   care = val[15:0];
      mbps_pkg::CFG_LEN:    len_reg = val[4:0];
      default: ;
    endcase
  endfunction

  // lengths above PAT_BYTES act as a full-size pattern
  function int unsigned eff_len();
    return (len_reg > mbps_pkg::PAT_BYTES) ? mbps_pkg::PAT_BYTES : len_reg;
  endfunction

  function logic [7:0] pattern_byte(int unsigned i);
    logic [127:0] pat;
    pat = {pat_hi, pat_lo};
    return pat[8*i +: 8];
  endfunction

  function void note_byte(mbps_pkg::mbps_in_t item);
    int unsigned n;
    int back;
    bit hit;
    logic [31:0] start;
    logic [7:0] b;
    mbps_pkg::mbps_out_t r;
    n = eff_len();
    hit = 1'b0;
    start = '0;
    if (!reported) begin
      if (n == 0) begin
        hit = 1'b1;
        start = seen;
      end else if (seen >= n - 1) begin
        hit = 1'b1;
        for (int i = 0; i < n; i++) begin
          back = n - 1 - i;
          b = (back == 0) ? item.data_byte : window[back-1];
          if (care[i] && b != pattern_byte(i)) hit = 1'b0;
        end
        start = seen - 32'(n - 1);
      end
      if (hit) begin
        reported = 1'b1;
        r.found = 1'b1;
        r.match_offset = start;
        pending_results.push_back(r);
        n_found++;
      end else if (item.last_byte) begin
        r = '0;
        pending_results.push_back(r);
        n_missed++;
      end
    end
    n_bytes++;
    if (item.last_byte) begin
      clear_scan();
    end else begin
      for (int k = 14; k > 0; k--) window[k] = window[k-1];
      window[0] = item.data_byte;
      if (seen != '1) seen++;
    end
  endfunction

  function void check_result(mbps_pkg::mbps_out_t got);
    mbps_pkg::mbps_out_t want;
    if (pending_results.size() == 0) begin
      $display("%0t: unexpected result found=%0d match_offset=%0d",
               $time, got.found, got.match_offset);
      errors++;
      return;
    end
    want = pending_results.pop_front();
    if (got.found !== want.found) begin
      $display("%0t: found mismatch, expected %0d, actual %0d", $time, want.found, got.found);
      errors++;
    end
    if (got.match_offset !== want.match_offset) begin
      $display("%0t: match_offset mismatch, expected %0d, actual %0d",
               $time, want.match_offset, got.match_offset);
      errors++;
    end
  endfunction

  function int pending();
    return pending_results.size();
  endfunction

  function void check_drained();
    if (pending_results.size() != 0) begin
      $display("%0t: %0d results never arrived", $time, pending_results.size());
      errors++;
    end
  endfunction
endclass

module testbench;
  import mbps_pkg::*;

  typedef enum int {IMG_PLANTED, IMG_BROKEN, IMG_NOISE} img_kind_e;

  localparam int TARGET_BYTES = 1250;
  localparam int QUIET_FROM   = 1050;
  localparam int HOLD_CYCLES  = 60;
  localparam int DRAIN_WAIT   = 4;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  byte_valid = 1'b0;
  logic                  byte_ready;
  mbps_in_t              byte_item = '0;
  logic                  res_valid;
  logic                  res_ready = 1'b0;
  mbps_out_t             res;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_ADDR_W-1:0] cfg_addr = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  scan_scoreboard scan_sb;
  bit quiet = 1'b0;
  bit hold_req = 1'b0;
  int n_images = 0;
  int n_settings = 0;

  masked_byte_pattern_scan u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (byte_valid),
    .in_ready_o  (byte_ready),
    .in_i        (byte_item),
    .out_valid_o (res_valid),
    .out_ready_i (res_ready),
    .out_o       (res),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_addr_i  (cfg_addr),
    .cfg_data_i  (cfg_data)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  initial begin
    #2_000_000;
    $display("== FAIL ==");
    $finish;
  end

  always @(posedge clk_i) begin
    if (rst_ni && byte_valid && byte_ready) scan_sb.note_byte(byte_item);
    if (rst_ni && res_valid && res_ready) scan_sb.check_result(res);
  end

  // result side: random stall bursts, plus one long hold on request
  initial begin
    int gap_left;
    gap_left = 0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        gap_left = HOLD_CYCLES;
      end
      if (gap_left > 0) begin
        gap_left--;
        res_ready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        gap_left = $urandom_range(0, 3);
        res_ready <= 1'b0;
      end else begin
        res_ready <= 1'b1;
      end
    end
  end

  // returns at the edge that takes the item; the next call drives at the following negedge
  task automatic send_byte(mbps_in_t item);
    @(negedge clk_i);
    if (!quiet && $urandom_range(0, 4) == 0) begin
      byte_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk_i);
    end
    byte_valid <= 1'b1;
    byte_item  <= item;
    do @(posedge clk_i); while (!byte_ready);
  endtask

  task automatic block_idle();
    @(negedge clk_i);
    byte_valid <= 1'b0;
    while (scan_sb.pending() > 0) @(negedge clk_i);
    // a byte that produces no result may still be in flight
    repeat (DRAIN_WAIT) @(negedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_ADDR_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    @(negedge clk_i);
    cfg_valid <= 1'b1;
    cfg_addr  <= idx;
    cfg_data  <= val;
    do @(posedge clk_i); while (!cfg_ready);
    scan_sb.write_reg(idx, val);
  endtask

  task automatic cfg_stop();
    @(negedge clk_i);
    cfg_valid <= 1'b0;
    n_settings++;
  endtask

  task automatic write_all(logic [63:0] lo, logic [63:0] hi, logic [63:0] care_val,
                           logic [63:0] len_val);
    write_reg(CFG_PAT_LO, lo);
    write_reg(CFG_PAT_HI, hi);
    write_reg(CFG_CARE, care_val);
    write_reg(CFG_LEN, len_val);
    cfg_stop();
  endtask

  task automatic run_image(int unsigned n, img_kind_e kind);
    logic [7:0] img [$];
    int unsigned plen;
    int unsigned at;
    int unsigned j;
    plen = scan_sb.eff_len();
    for (int i = 0; i < n; i++) begin
      // near-miss bytes drawn from the pattern itself
      if (plen > 0 && $urandom_range(0, 2) == 0)
        img.push_back(scan_sb.pattern_byte($urandom_range(0, plen - 1)));
      else
        img.push_back(8'($urandom));
    end
    if (kind != IMG_NOISE && plen > 0) begin
      if (n <= plen || $urandom_range(0, 4) == 0) at = $urandom_range(0, n - 1);
      else at = $urandom_range(0, n - plen);
      for (int i = 0; i < plen && at + i < n; i++)
        if (scan_sb.care[i]) img[at+i] = scan_sb.pattern_byte(i);
      if (kind == IMG_BROKEN) begin
        j = $urandom_range(0, plen - 1);
        if (at + j < n) img[at+j] ^= 8'(1 << $urandom_range(0, 7));
      end
    end
    for (int i = 0; i < n; i++) send_byte({img[i], 1'(i == n - 1)});
    n_images++;
  endtask

  initial begin
    int unsigned r;
    int unsigned n;
    logic [63:0] lo;
    logic [63:0] hi;
    logic [63:0] care_val;
    logic [63:0] len_val;
    int wait_cycles;
    img_kind_e kind;

    scan_sb = new();
    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;

    // reset settings: single zero byte, reported match then a fresh miss
    send_byte({8'h00, 1'b0});
    send_byte({8'hFF, 1'b1});
    send_byte({8'hFF, 1'b1});

    // empty pattern hits on the very first byte, here also the last one
    block_idle();
    write_reg(CFG_LEN, 64'd0);
    cfg_stop();
    send_byte({8'h5A, 1'b1});

    // 12 ?? 56 with a wildcard in the middle; hit on the last byte, then truncated
    block_idle();
    write_reg(CFG_PAT_LO, 64'hA5C3_0F99_0056_3412);
    write_reg(CFG_CARE, 64'h0000_0000_0000_FFFD);
    write_reg(CFG_LEN, 64'd3);
    cfg_stop();
    send_byte({8'h12, 1'b0});
    send_byte({8'h77, 1'b0});
    send_byte({8'h56, 1'b1});
    send_byte({8'h12, 1'b0});
    send_byte({8'h34, 1'b1});

    // settings change mid-image: window contents carry over
    send_byte({8'hAA, 1'b0});
    send_byte({8'h12, 1'b0});
    block_idle();
    write_reg(CFG_LEN, 64'd2);
    write_reg(CFG_CARE, 64'h0000_0000_0000_0003);
    cfg_stop();
    send_byte({8'h34, 1'b1});

    // oversize length, all wildcards, all-ones pattern
    block_idle();
    write_all('1, '1, 64'd0, 64'd31);
    for (int i = 0; i < 16; i++) send_byte({(i % 2) ? 8'hFF : 8'h00, 1'(i == 15)});

    // back pressure: every image hits at once while results are held off
    block_idle();
    write_all({$urandom, $urandom}, {$urandom, $urandom}, 64'hFFFF, 64'd0);
    @(posedge clk_i);
    hold_req = 1'b1;
    for (int i = 0; i < 24; i++) run_image($urandom_range(1, 3), IMG_NOISE);

    for (int phase = 0; scan_sb.n_bytes < TARGET_BYTES; phase++) begin
      quiet = (phase % 4 == 3) || (scan_sb.n_bytes > QUIET_FROM);
      block_idle();
      r = $urandom_range(0, 7);
      lo = (r == 0) ? '0 : (r == 1) ? '1 : {$urandom, $urandom};
      r = $urandom_range(0, 7);
      hi = (r == 0) ? '0 : (r == 1) ? '1 : {$urandom, $urandom};
      r = $urandom_range(0, 7);
      care_val = {$urandom, $urandom};
      if (r == 0) care_val[15:0] = '0;
      else if (r < 3) care_val[15:0] = '1;
      r = $urandom_range(0, 9);
      len_val = {$urandom, $urandom};
      case (r)
        0: len_val[4:0] = 5'd0;
        1: len_val[4:0] = 5'd16;
        2: len_val[4:0] = 5'($urandom_range(17, 31));
        default: len_val[4:0] = 5'($urandom_range(1, 6));
      endcase
      write_all(lo, hi, care_val, len_val);
      repeat ($urandom_range(3, 8)) begin
        r = $urandom_range(0, 5);
        kind = (r < 3) ? IMG_PLANTED : (r < 5) ? IMG_BROKEN : IMG_NOISE;
        n = ($urandom_range(0, 5) == 0) ? $urandom_range(17, 48) : $urandom_range(1, 20);
        run_image(n, kind);
      end
    end

    @(negedge clk_i);
    byte_valid <= 1'b0;
    wait_cycles = 0;
    while (scan_sb.pending() > 0 && wait_cycles < 2000) begin
      @(negedge clk_i);
      wait_cycles++;
    end
    repeat (10) @(negedge clk_i);
    scan_sb.check_drained();

    $display("Scanned %0d bytes in %0d images under %0d register settings,",
             scan_sb.n_bytes, n_images, n_settings);
    $display("with %0d matches and %0d not-found results predicted; %0d errors.",
             scan_sb.n_found, scan_sb.n_missed, scan_sb.errors);
    if (scan_sb.errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
